// ----- design/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, constants and the data type that moves along the root chain.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned GradW  = 11;
  localparam int unsigned AbsW   = 10;
  localparam int unsigned SqW    = 2 * AbsW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned RootSteps = 16;
  localparam int unsigned RadW   = 2 * RootSteps;
  localparam int unsigned RootW  = RootSteps;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned MagW   = 8;
  localparam logic [MagW-1:0] MagMax = 8'd255;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } root_t;

endpackage

// ----- design/sobel_edge_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3 window
// Computes min(255, floor(sqrt(gx^2 + gy^2))) for one window per beat.
//
//   Channel  Signals                            Direction
//   in       in_valid_i, in_ready_o, pix_*_i    window beat into the block
//   out      out_valid_o, out_ready_i, edge_mag_o  magnitude beat out
//
// One window is accepted per clock while the output is not stalled. The path
// has three front-end stages, sixteen root cells and one output register.
// Every stage has its own valid bit, so bubbles close up during a stall.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [sem_pkg::PixW-1:0] pix_r0_c0_i,
  input  logic [sem_pkg::PixW-1:0] pix_r0_c1_i,
  input  logic [sem_pkg::PixW-1:0] pix_r0_c2_i,
  input  logic [sem_pkg::PixW-1:0] pix_r1_c0_i,
  input  logic [sem_pkg::PixW-1:0] pix_r1_c1_i,
  input  logic [sem_pkg::PixW-1:0] pix_r1_c2_i,
  input  logic [sem_pkg::PixW-1:0] pix_r2_c0_i,
  input  logic [sem_pkg::PixW-1:0] pix_r2_c1_i,
  input  logic [sem_pkg::PixW-1:0] pix_r2_c2_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [sem_pkg::MagW-1:0] edge_mag_o
);
  import sem_pkg::*;

  logic              chain_valid [RootSteps+1];
  logic              chain_ready [RootSteps+1];
  root_t             chain_data  [RootSteps+1];
  logic              out_valid_q, out_rdy;
  logic [MagW-1:0]   mag_q, mag_d;
  logic              unused_center;

  assign unused_center = ^pix_r1_c1_i;

  sem_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .p00_i   (pix_r0_c0_i),
    .p01_i   (pix_r0_c1_i),
    .p02_i   (pix_r0_c2_i),
    .p10_i   (pix_r1_c0_i),
    .p12_i   (pix_r1_c2_i),
    .p20_i   (pix_r2_c0_i),
    .p21_i   (pix_r2_c1_i),
    .p22_i   (pix_r2_c2_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar k = 0; k < RootSteps; k++) begin : g_cell
    sem_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign out_rdy                = !out_valid_q || out_ready_i;
  assign chain_ready[RootSteps] = out_rdy;

  always_comb begin
    if (chain_data[RootSteps].root > RootW'(MagMax)) begin
      mag_d = MagMax;
    end else begin
      mag_d = chain_data[RootSteps].root[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= chain_valid[RootSteps] | (unused_center & 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && chain_valid[RootSteps]) begin
      mag_q <= mag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_mag_o  = mag_q;

endmodule

// ----- design/sem_front.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient front end
// Forms both gradient magnitudes, squares them and sums the squares into the
// radicand, over three registered stages with their own handshake.
// ----------------------------------------------------------------------------
module sem_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [sem_pkg::PixW-1:0] p00_i,
  input  logic [sem_pkg::PixW-1:0] p01_i,
  input  logic [sem_pkg::PixW-1:0] p02_i,
  input  logic [sem_pkg::PixW-1:0] p10_i,
  input  logic [sem_pkg::PixW-1:0] p12_i,
  input  logic [sem_pkg::PixW-1:0] p20_i,
  input  logic [sem_pkg::PixW-1:0] p21_i,
  input  logic [sem_pkg::PixW-1:0] p22_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output sem_pkg::root_t         data_o
);
  import sem_pkg::*;

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [AbsW-1:0]   ax_q, ay_q, ax_d, ay_d;
  logic [SqW-1:0]    sx_q, sy_q;
  logic [SumW-1:0]   sum_q;
  logic signed [GradW-1:0] gx, gy;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    gx = signed'(GradW'(p02_i) + GradW'({p12_i, 1'b0}) + GradW'(p22_i))
       - signed'(GradW'(p00_i) + GradW'({p10_i, 1'b0}) + GradW'(p20_i));
    gy = signed'(GradW'(p20_i) + GradW'({p21_i, 1'b0}) + GradW'(p22_i))
       - signed'(GradW'(p00_i) + GradW'({p01_i, 1'b0}) + GradW'(p02_i));
    ax_d = gx[GradW-1] ? AbsW'(-gx) : AbsW'(gx);
    ay_d = gy[GradW-1] ? AbsW'(-gy) : AbsW'(gy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
    if (rdy2 && v1_q) begin
      sx_q <= SqW'(ax_q) * SqW'(ax_q);
      sy_q <= SqW'(ay_q) * SqW'(ay_q);
    end
    if (rdy3 && v2_q) begin
      sum_q <= SumW'(sx_q) + SumW'(sy_q);
    end
  end

  assign valid_o     = v3_q;
  assign data_o.rem  = '0;
  assign data_o.root = '0;
  assign data_o.rad  = RadW'(sum_q);

endmodule

// ----- design/sem_root_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: brings down two radicand bits, tries the
// next root bit and registers the partial remainder and root.
// ----------------------------------------------------------------------------
module sem_root_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  sem_pkg::root_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output sem_pkg::root_t data_o
);
  import sem_pkg::*;

  logic            valid_q;
  root_t           data_q, data_d;
  logic [RemW-1:0] rem_sh, trial;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem_sh = {data_i.rem[RemW-3:0], data_i.rad[RadW-1:RadW-2]};
    trial  = {1'b0, data_i.root, 2'b01};
    data_d.rad = {data_i.rad[RadW-3:0], 2'b00};
    if (trial <= rem_sh) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
